@@ rtl/core/b64d_pkg.sv @@
package b64d_pkg;

  // One queued job: a group of bytes to emit, or the end of a stream.
  typedef struct packed {
    logic [23:0] bits;     // bytes, most significant first
    logic [1:0]  nbytes;   // bytes to emit from the top of bits
    logic        finish;   // end of stream: mark last result, clear total
  } b64d_job_t;

  typedef enum logic {
    CMD_DECODE = 1'b0,
    CMD_FINISH = 1'b1
  } b64d_cmd_t;

  localparam logic [7:0] CHAR_PAD = 8'h3d;  // '='

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } b64d_sym_t;

  // Both alphabets; '=' maps to zero and is flagged separately by the caller.
  function automatic b64d_sym_t b64d_map(input logic [7:0] c);
    b64d_sym_t r;
    r.ok    = 1'b1;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b || c == 8'h2d) begin
      r.value = 6'h3e;
    end else if (c == 8'h2f || c == 8'h5f) begin
      r.value = 6'h3f;
    end else if (c == CHAR_PAD) begin
      r.value = 6'd0;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/b64d_front.sv @@
module b64d_front import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       command,
  input  logic [7:0] symbol,
  output logic       push,
  output b64d_job_t  job
);

  logic [1:0]  group_position;
  logic [23:0] group_bits;
  logic [1:0]  pad_count;

  logic [1:0]  group_position_next;
  logic [23:0] group_bits_next;
  logic [1:0]  pad_count_next;

  b64d_sym_t   sym;
  logic [23:0] shifted;
  logic [1:0]  pad_inc;
  logic [23:0] aligned;
  logic [1:0]  flush_n;

  assign sym     = b64d_map(symbol);
  assign shifted = {group_bits[17:0], sym.value};
  assign pad_inc = (symbol == CHAR_PAD && pad_count != 2'd3) ? pad_count + 2'd1 : pad_count;

  // left-justify a partial group for flushing
  always_comb begin
    case (group_position)
      2'd1:    aligned = {group_bits[5:0], 18'd0};
      2'd2:    aligned = {group_bits[11:0], 12'd0};
      2'd3:    aligned = {group_bits[17:0], 6'd0};
      default: aligned = 24'd0;
    endcase
    if ({1'b0, group_position} > 3'd1 + {1'b0, pad_count}) begin
      flush_n = 2'(group_position - 2'd1 - pad_count);
    end else begin
      flush_n = 2'd0;
    end
  end

  always_comb begin
    group_position_next = group_position;
    group_bits_next     = group_bits;
    pad_count_next      = pad_count;
    push                = 1'b0;
    job.bits            = shifted;
    job.nbytes          = 2'(2'd3 - pad_inc);
    job.finish          = 1'b0;
    if (accept) begin
      if (b64d_cmd_t'(command) == CMD_FINISH) begin
        push                = 1'b1;
        job.bits            = aligned;
        job.nbytes          = flush_n;
        job.finish          = 1'b1;
        group_position_next = 2'd0;
        group_bits_next     = 24'd0;
        pad_count_next      = 2'd0;
      end else if (sym.ok) begin
        if (group_position == 2'd3) begin
          push                = (pad_inc != 2'd3);  // three or more pads give nothing
          group_position_next = 2'd0;
          group_bits_next     = 24'd0;
          pad_count_next      = 2'd0;
        end else begin
          group_position_next = group_position + 2'd1;
          group_bits_next     = shifted;
          pad_count_next      = pad_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= 2'd0;
      group_bits     <= 24'd0;
      pad_count      <= 2'd0;
    end else begin
      group_position <= group_position_next;
      group_bits     <= group_bits_next;
      pad_count      <= pad_count_next;
    end
  end

endmodule

@@ rtl/core/b64d_queue.sv @@
module b64d_queue import b64d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  b64d_job_t push_job,
  input  logic      pop,
  output logic      full,
  output logic      nonempty,
  output b64d_job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64d_job_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/b64d_back.sv @@
module b64d_back import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  b64d_job_t   head,
  input  logic        out_stall,
  output logic        pop,
  output logic        out_valid,
  output logic [7:0]  data_byte,
  output logic        byte_valid,
  output logic        is_end,
  output logic [31:0] total_bytes
);

  logic [1:0]  idx;
  logic [31:0] byte_total;
  logic [1:0]  last_idx;
  logic        last;
  logic        taken;

  // a finish with nothing to flush still gives one empty end marker
  assign last_idx   = (head.nbytes == 2'd0) ? 2'd0 : head.nbytes - 2'd1;
  assign last       = (idx == last_idx);
  assign out_valid  = head_valid;
  assign taken      = head_valid && !out_stall;
  assign pop        = taken && last;
  assign byte_valid = (head.nbytes != 2'd0);
  assign is_end     = head.finish && last;

  always_comb begin
    case (idx)
      2'd0:    data_byte = head.bits[23:16];
      2'd1:    data_byte = head.bits[15:8];
      2'd2:    data_byte = head.bits[7:0];
      default: data_byte = 8'd0;
    endcase
    if (!byte_valid) begin
      data_byte = 8'd0;
    end
    if (byte_valid && byte_total != 32'hffff_ffff) begin
      total_bytes = byte_total + 32'd1;
    end else begin
      total_bytes = byte_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= 2'd0;
      byte_total <= 32'd0;
    end else if (taken) begin
      idx        <= last ? 2'd0 : idx + 2'd1;
      byte_total <= (head.finish && last) ? 32'd0 : total_bytes;
    end
  end

endmodule

@@ rtl/core/base64_stream_decoder.sv @@
// Channel  Direction  Handshake           Item fields
// in       input      in_valid/in_stall   command, symbol
// out      output     out_valid/out_stall data_byte, byte_valid, is_end, total_bytes
//
// One character item is taken every cycle while the job queue has room; the
// front decodes it in the cycle it is accepted. A completed group (unless it
// holds three or more pads) or a finish queues one job, and the back emits its
// results one per cycle while out_stall is low. in_stall rises only when
// QUEUE_DEPTH jobs are waiting. Synchronous reset clears the group state,
// the queue and the byte total; the queue storage itself needs no reset.
module base64_stream_decoder import b64d_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  symbol,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic        byte_valid,
  output logic        is_end,
  output logic [31:0] total_bytes
);

  logic      accept;
  logic      push;
  b64d_job_t job;
  logic      pop;
  logic      full;
  logic      nonempty;
  b64d_job_t head;

  // stall on a full queue only, so valid and stall stay independent
  assign in_stall = full;
  assign accept   = in_valid && !full;

  // front: maps characters, builds groups, queues byte jobs
  b64d_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (command),
    .symbol  (symbol),
    .push    (push),
    .job     (job)
  );

  // decouples the one-per-cycle input (while the queue is not full) from the multi-result output
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .head     (head)
  );

  // back: walks each job's bytes and keeps the saturating stream total
  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (nonempty),
    .head        (head),
    .out_stall   (out_stall),
    .pop         (pop),
    .out_valid   (out_valid),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .is_end      (is_end),
    .total_bytes (total_bytes)
  );

endmodule
